// ===== sv/tlprq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlprq_pkg
// Shared types and codes for the three-level priority run queue.
// ----------------------------------------------------------------------------
package tlprq_pkg;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 8;
    localparam int PRI_W    = 2;
    localparam int STATUS_W = 2;
    localparam int LEVELS   = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ   = 2'd0,
        KIND_DEQ   = 2'd1,
        KIND_FLUSH = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPRI = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    localparam logic [PRI_W-1:0] LVL_LOW  = 2'd0;
    localparam logic [PRI_W-1:0] LVL_MID  = 2'd1;
    localparam logic [PRI_W-1:0] LVL_HIGH = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   thread_id;
        logic [PRI_W-1:0]  priority_req;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     next_thread;
        logic [PRI_W-1:0]    from_level;
    } t_rsp;

endpackage

// ===== sv/tlprq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tlprq_cmd_if
// Command channel: valid/ready handshake carrying one queue operation.
// ----------------------------------------------------------------------------
interface tlprq_cmd_if import tlprq_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tlprq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tlprq_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface tlprq_rsp_if import tlprq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tlprq_ram.sv =====
// ----------------------------------------------------------------------------
// tlprq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tlprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== sv/three_level_priority_run_queue.sv =====
// ----------------------------------------------------------------------------
// three_level_priority_run_queue
// Strict-priority run queue: three FIFOs of thread IDs in RAM, dequeue from
// the highest non-empty level.
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | handshake
//  --------+-----+---------------------------------------+-------------
//  i_cmd   | in  | kind, thread_id, priority_req         | valid/ready
//  o_rsp   | out | status, next_thread, from_level       | valid/ready
//
//  One operation per cycle while o_rsp is not stalled; each result appears in the
//  cycle after its command beat, as the store RAM returns the head entry registered.
//  Head pointers and fill counts sit in flops and update at the command beat,
//  so back-to-back operations on the same level see current state.
//  i_rst_n (synchronous) empties all queues; store contents are not cleared.
//  A stalled result holds o_rsp and blocks i_cmd until it is taken.
// ----------------------------------------------------------------------------
module three_level_priority_run_queue import tlprq_pkg::*; #(
    parameter int QUEUE_DEPTH = 32,
    parameter int ID_BITS     = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tlprq_cmd_if.sink    i_cmd,
    tlprq_rsp_if.source  o_rsp
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int STORE_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;

    logic [PTR_W-1:0]    r_head [LEVELS];
    logic [PTR_W-1:0]    n_head [LEVELS];
    logic [CNT_W-1:0]    r_fill [LEVELS];
    logic [CNT_W-1:0]    n_fill [LEVELS];

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    logic                r_deq_ok;
    logic                n_deq_ok;
    logic [PRI_W-1:0]    r_lvl;
    logic [PRI_W-1:0]    n_lvl;

    logic                accept;
    logic [LEVELS-1:0]   wr_en;
    logic [LEVELS-1:0]   rd_en;
    logic [PTR_W-1:0]    tail;
    logic [SUM_W-1:0]    tail_sum;
    logic [PRI_W-1:0]    enq_lvl;
    logic [PRI_W-1:0]    deq_lvl;
    logic                any_ready;
    logic [STORE_W-1:0]  wr_data;
    logic [STORE_W-1:0]  rd_data [LEVELS];

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign wr_data     = i_cmd.data.thread_id[STORE_W-1:0];

    // bad priority maps to low here; the write is suppressed anyway
    assign enq_lvl = (i_cmd.data.priority_req > LVL_HIGH) ? LVL_LOW
                                                          : i_cmd.data.priority_req;

    assign tail_sum = SUM_W'(r_head[enq_lvl]) + SUM_W'(r_fill[enq_lvl]);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                    : PTR_W'(tail_sum);

    always_comb begin
        any_ready = 1'b1;
        priority if (r_fill[LVL_HIGH] != '0) begin
            deq_lvl = LVL_HIGH;
        end else if (r_fill[LVL_MID] != '0) begin
            deq_lvl = LVL_MID;
        end else if (r_fill[LVL_LOW] != '0) begin
            deq_lvl = LVL_LOW;
        end else begin
            deq_lvl   = LVL_LOW;
            any_ready = 1'b0;
        end
    end

    always_comb begin
        n_head   = r_head;
        n_fill   = r_fill;
        wr_en    = '0;
        rd_en    = '0;
        n_status = ST_OK;
        n_deq_ok = 1'b0;
        n_lvl    = LVL_LOW;
        if (accept) begin
            unique case (i_cmd.data.kind)
                KIND_ENQ: begin
                    priority if (i_cmd.data.priority_req > LVL_HIGH) begin
                        n_status = ST_BADPRI;
                    end else if (r_fill[enq_lvl] == CNT_W'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en[enq_lvl]  = 1'b1;
                        n_fill[enq_lvl] = r_fill[enq_lvl] + 1'b1;
                    end
                end
                KIND_DEQ: begin
                    if (!any_ready) begin
                        n_status = ST_EMPTY;
                    end else begin
                        rd_en[deq_lvl]  = 1'b1;
                        n_fill[deq_lvl] = r_fill[deq_lvl] - 1'b1;
                        n_head[deq_lvl] = (r_head[deq_lvl] == PTR_W'(QUEUE_DEPTH - 1))
                                        ? '0 : r_head[deq_lvl] + 1'b1;
                        n_deq_ok        = 1'b1;
                        n_lvl           = deq_lvl;
                    end
                end
                KIND_FLUSH: begin
                    for (int l = 0; l < LEVELS; l++) begin
                        n_head[l] = '0;
                        n_fill[l] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_fill[l] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_deq_ok <= n_deq_ok;
            r_lvl    <= n_lvl;
        end
    end

    for (genvar g = 0; g < LEVELS; g++) begin : g_store
        tlprq_ram #(
            .WIDTH (STORE_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en[g]),
            .i_wr_addr (tail),
            .i_wr_data (wr_data),
            .i_rd_en   (rd_en[g]),
            .i_rd_addr (r_head[g]),
            .o_rd_data (rd_data[g])
        );
    end

    // RAM read data holds while the result is stalled: no read is issued
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.data.status      = r_status;
    assign o_rsp.data.next_thread = r_deq_ok ? ID_W'(rd_data[r_lvl]) : '0;
    assign o_rsp.data.from_level  = r_lvl;

endmodule

// ===== sv/tlprq_checker.sv =====
// ----------------------------------------------------------------------------
// tlprq_checker
// Port-level checks for the run queue, bound to the top level.
// ----------------------------------------------------------------------------
module tlprq_checker import tlprq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cmd_valid,
    input logic i_cmd_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled result changed");

    // every command beat yields a result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> i_rsp_valid)
        else $error("command beat without result");

    // no new command while a result is stuck
    a_block_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_cmd_ready)
        else $error("command taken while result stalled");

    // a failed result carries a zero identifier and the low level
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.status != ST_OK
            |-> i_rsp_data.next_thread == '0 && i_rsp_data.from_level == LVL_LOW)
        else $error("nonzero fields in failed result");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_data.from_level <= LVL_HIGH)
        else $error("from_level out of range");

endmodule

bind three_level_priority_run_queue tlprq_checker u_tlprq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-level priority run queue. A short directed
// run covers the corner cases, then segmented random traffic (fill, drain and
// blended phases) is scored against a ring-buffer model of the three levels.
// ----------------------------------------------------------------------------
module tb_top;
    import tlprq_pkg::*;

    localparam int QDEPTH       = 32;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 160;
    localparam int TAIL_CYCLES  = 16;
    localparam int STALL_LIMIT  = 4000;
    localparam int PRINT_CAP    = 100;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [PRI_W-1:0]  PRI_BAD     = 2'd3;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BLEND
    } t_mix;

    // Ring-buffer copy of the three levels plus the results still owed.
    class run_queue_model;
        logic [ID_W-1:0] slots [LEVELS][QDEPTH];
        int unsigned     head [LEVELS];
        int unsigned     fill [LEVELS];
        t_rsp            owed_rsps [$];
        int unsigned     errors;
        int unsigned     rsp_count;

        function new();
            clear_levels();
            errors    = 0;
            rsp_count = 0;
        endfunction

        function void clear_levels();
            for (int l = 0; l < LEVELS; l++) begin
                head[l] = 0;
                fill[l] = 0;
            end
        endfunction

        function t_rsp predict_rsp(t_cmd c);
            t_rsp        r;
            int          lvl;
            int unsigned tail;
            r = '0;
            r.status = ST_OK;
            case (c.kind)
                KIND_ENQ: begin
                    if (c.priority_req == PRI_BAD) begin
                        r.status = ST_BADPRI;
                    end else if (fill[c.priority_req] == QDEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        tail = (head[c.priority_req] + fill[c.priority_req]) % QDEPTH;
                        slots[c.priority_req][tail] = c.thread_id;
                        fill[c.priority_req]++;
                    end
                end
                KIND_DEQ: begin
                    // strict priority: scan from the high level down
                    lvl = LEVELS - 1;
                    while (lvl >= 0 && fill[lvl] == 0)
                        lvl--;
                    if (lvl < 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.next_thread = slots[lvl][head[lvl]];
                        r.from_level  = lvl[PRI_W-1:0];
                        head[lvl]     = (head[lvl] + 1) % QDEPTH;
                        fill[lvl]--;
                    end
                end
                KIND_FLUSH: begin
                    clear_levels();
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void take_command(t_cmd c);
            owed_rsps.push_back(predict_rsp(c));
        endfunction

        task report(string msg);
            // cap the printout on a badly broken block, keep counting
            if (errors < PRINT_CAP)
                $display("tb_top: mismatch: %s", msg);
            errors++;
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            rsp_count++;
            if (owed_rsps.size() == 0) begin
                report($sformatf("result %0d arrived with none owed (status %0d id %02h lvl %0d)",
                                 rsp_count, got.status, got.next_thread, got.from_level));
            end else begin
                want = owed_rsps.pop_front();
                if (got.status !== want.status)
                    report($sformatf("result %0d status %0d, want %0d",
                                     rsp_count, got.status, want.status));
                if (got.next_thread !== want.next_thread)
                    report($sformatf("result %0d next_thread %02h, want %02h",
                                     rsp_count, got.next_thread, want.next_thread));
                if (got.from_level !== want.from_level)
                    report($sformatf("result %0d from_level %0d, want %0d",
                                     rsp_count, got.from_level, want.from_level));
            end
        endtask

        task check_drained();
            if (owed_rsps.size() != 0)
                report($sformatf("%0d results never arrived", owed_rsps.size()));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    tlprq_cmd_if cmd_ch ();
    tlprq_rsp_if rsp_ch ();

    three_level_priority_run_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    run_queue_model rq_model;
    bit             calm;
    bit             hold_req;
    int unsigned    stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Offer one beat, with an occasional random gap in front of it, and wait for the take.
    // valid is left high so back-to-back beats need no toggle.
    task automatic send_cmd(input t_cmd c);
        if (!calm && $urandom_range(99) < 25) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] tid,
                           input logic [PRI_W-1:0] pri);
        t_cmd c;
        c.kind         = kind;
        c.thread_id    = tid;
        c.priority_req = pri;
        send_cmd(c);
    endtask

    function automatic t_cmd random_cmd(t_mix mix, logic [PRI_W-1:0] favored);
        t_cmd        c;
        int unsigned roll;
        int unsigned enq_pct;
        c.thread_id    = ID_W'($urandom_range((1 << ID_W) - 1));
        c.priority_req = PRI_W'($urandom_range(LEVELS - 1));
        if (mix == MIX_FILL && $urandom_range(99) < 80)
            c.priority_req = favored;
        if ($urandom_range(99) < 3)
            c.priority_req = PRI_BAD;
        case (mix)
            MIX_FILL:  enq_pct = 85;
            MIX_DRAIN: enq_pct = 15;
            default:   enq_pct = 48;
        endcase
        roll = $urandom_range(99);
        if (roll < enq_pct)
            c.kind = KIND_ENQ;
        else if (roll == 99)
            c.kind = KIND_UNUSED;
        else if (mix == MIX_BLEND && roll >= 95)
            c.kind = KIND_FLUSH;
        else
            c.kind = KIND_DEQ;
        return c;
    endfunction

    // Result sink: random backpressure, calm stretches, one long hold-off.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (calm) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= 30);
            end
        end
    end

    // Monitor and watchdog: score every beat on both channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                rq_model.take_command(cmd_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
                rq_model.check_result(rsp_ch.data);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_cmd            c;
        t_mix            mix;
        logic [PRI_W-1:0] fav;
        int              sent;
        int              seg_len;
        bit              held;
        bit              paused;

        rq_model     = new();
        calm         = 1'b0;
        hold_req     = 1'b0;
        stall_cycles = 0;
        held         = 1'b0;
        paused       = 1'b0;
        sent         = 0;
        i_rst_n      <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_op(KIND_DEQ,    8'h00, LVL_LOW);   // nothing queued
        send_op(KIND_UNUSED, 8'hff, PRI_BAD);   // unused kind, no effect
        send_op(KIND_ENQ,    8'h00, LVL_LOW);
        send_op(KIND_ENQ,    8'hff, LVL_MID);
        send_op(KIND_ENQ,    8'ha5, LVL_HIGH);
        send_op(KIND_ENQ,    8'h5a, PRI_BAD);   // rejected level
        send_op(KIND_ENQ,    8'h3c, LVL_LOW);
        send_op(KIND_UNUSED, 8'h00, LVL_LOW);
        send_op(KIND_DEQ,    8'hff, PRI_BAD);
        send_op(KIND_DEQ,    8'h00, LVL_LOW);
        send_op(KIND_DEQ,    8'h00, LVL_LOW);
        send_op(KIND_DEQ,    8'h00, LVL_LOW);
        send_op(KIND_DEQ,    8'h00, LVL_LOW);   // drained again
        send_op(KIND_ENQ,    8'h81, LVL_HIGH);
        send_op(KIND_ENQ,    8'h7e, LVL_MID);
        send_op(KIND_FLUSH,  8'hff, PRI_BAD);
        send_op(KIND_DEQ,    8'h00, LVL_LOW);   // flushed
        send_op(KIND_ENQ,    8'h01, LVL_LOW);
        send_op(KIND_ENQ,    8'hfe, LVL_HIGH);
        send_op(KIND_DEQ,    8'h00, LVL_LOW);
        send_op(KIND_DEQ,    8'h00, LVL_LOW);
        send_op(KIND_FLUSH,  8'h00, LVL_LOW);

        // random phases
        while (sent < RANDOM_ITEMS) begin
            mix     = t_mix'($urandom_range(2));
            fav     = PRI_W'($urandom_range(LEVELS - 1));
            seg_len = $urandom_range(30, 90);
            calm    = (sent >= 560 && sent < 700);
            if (!held && sent >= 200) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && sent >= 450) begin
                // let every owed result come back before going on
                paused = 1'b1;
                cmd_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (rq_model.owed_rsps.size() != 0) @(posedge i_clk);
            end
            repeat (seg_len) begin
                c = random_cmd(mix, fav);
                send_cmd(c);
                if (c.kind != KIND_UNUSED)
                    sent++;
            end
        end
        calm = 1'b0;

        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rq_model.owed_rsps.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        rq_model.check_drained();
        if (rq_model.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
